### src/tmcw_pkg.sv
// Shared types, constants and helpers for the text-mode console writer.
// No dependencies; the files that use it refer to it by scoped names.
package tmcw_pkg;

    // Screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;
    // Cells that move during a scroll (all rows but the last)
    localparam int MOVE_CELLS = CELLS - COLUMNS;

    // Field widths
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;
    localparam int CELL_W = 2 * CHAR_W;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);

    // Character and attribute codes
    localparam logic [CHAR_W-1:0] NEWLINE_CODE   = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE     = 8'd32;
    localparam logic [CHAR_W-1:0] COLOR_AT_RESET = 8'd3;

    // Operation codes
    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    // Controller to datapath
    typedef struct packed {
        logic accept;   // take the transaction at the ports
        logic fill;     // write one blank cell of the fill sweep
        logic scroll;   // one step of the scroll sweep
        logic resp;     // load the result register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clear_req;    // the offered transaction clears the screen
        logic scroll_req;   // the offered transaction scrolls the screen
        logic fill_last;    // fill sweep at its last cell
        logic scroll_last;  // scroll sweep at its last write
    } t_dp_stat;

    // Linear cell address of a row and column
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(ADDR_W'(row) * ADDR_W'(COLUMNS));
        return ADDR_W'(base + ADDR_W'(col));
    endfunction

endpackage

### src/tmcw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tmcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/tmcw_ctrl.sv
// Controller state machine of the console writer: sequences accept, sweeps and result.
// Depends on tmcw_pkg.
module tmcw_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  tmcw_pkg::t_dp_stat i_stat,
    output tmcw_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy
);

    typedef enum logic [4:0] {
        S_INIT   = 5'b00001,
        S_IDLE   = 5'b00010,
        S_FILL   = 5'b00100,
        S_SCROLL = 5'b01000,
        S_RESP   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (i_stat.fill_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    if (i_stat.clear_req)       n_state = S_FILL;
                    else if (i_stat.scroll_req) n_state = S_SCROLL;
                    else                        n_state = S_RESP;
                end
            end
            S_FILL: begin
                if (i_stat.fill_last) n_state = S_RESP;
            end
            S_SCROLL: begin
                if (i_stat.scroll_last) n_state = S_RESP;
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: n_state = S_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Commands to the datapath
    always_comb begin
        o_cmd.accept = (r_state == S_IDLE) && i_start;
        o_cmd.fill   = (r_state == S_INIT) || (r_state == S_FILL);
        o_cmd.scroll = (r_state == S_SCROLL);
        o_cmd.resp   = (r_state == S_RESP);
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

### src/tmcw_dpath.sv
// Datapath of the console writer: cursor, colors, sweep counter, screen RAM, result register.
// Depends on tmcw_pkg and tmcw_ram.
module tmcw_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tmcw_pkg::t_dp_cmd             i_cmd,
    output tmcw_pkg::t_dp_stat            o_stat,
    input  logic [1:0]                    i_operation,
    input  logic [tmcw_pkg::CHAR_W-1:0]   i_char_code,
    input  logic [tmcw_pkg::ROW_W-1:0]    i_read_row,
    input  logic [tmcw_pkg::COL_W-1:0]    i_read_col,
    input  logic                          i_cfg_valid,
    input  logic [tmcw_pkg::CHAR_W-1:0]   i_cfg_text_color,
    output logic                          o_strobe,
    output logic [tmcw_pkg::CHAR_W-1:0]   o_cell_char,
    output logic [tmcw_pkg::CHAR_W-1:0]   o_cell_color,
    output logic [tmcw_pkg::ROW_W-1:0]    o_cursor_row,
    output logic [tmcw_pkg::COL_W-1:0]    o_cursor_col,
    output logic                          o_scrolled
);

    localparam int AW = tmcw_pkg::ADDR_W;
    localparam int CW = tmcw_pkg::CNT_W;

    logic [tmcw_pkg::ROW_W-1:0]  r_row, n_row;
    logic [tmcw_pkg::COL_W-1:0]  r_col, n_col;
    logic [tmcw_pkg::CHAR_W-1:0] r_text_color;
    logic [tmcw_pkg::CHAR_W-1:0] r_fill_color;
    logic [CW-1:0]               r_cnt;
    logic                        r_scrolled;
    logic                        r_rd_ok;
    logic                        r_strobe;
    logic [tmcw_pkg::CHAR_W-1:0] r_out_char;
    logic [tmcw_pkg::CHAR_W-1:0] r_out_color;
    logic [tmcw_pkg::ROW_W-1:0]  r_out_row;
    logic [tmcw_pkg::COL_W-1:0]  r_out_col;
    logic                        r_out_scrolled;

    logic                        w_is_put;
    logic                        w_is_nl;
    logic                        w_row_end;
    logic                        w_last_row;
    logic                        w_rd_in_range;
    logic [CW-1:0]               w_src;
    logic                        w_we;
    logic [AW-1:0]               w_waddr;
    logic [tmcw_pkg::CELL_W-1:0] w_wdata;
    logic [AW-1:0]               w_raddr;
    logic [tmcw_pkg::CELL_W-1:0] w_rdata;

    // Decode the offered transaction
    assign w_is_put   = (i_operation == tmcw_pkg::OP_PUT);
    assign w_is_nl    = (i_char_code == tmcw_pkg::NEWLINE_CODE);
    assign w_row_end  = w_is_nl || (r_col == tmcw_pkg::COL_W'(tmcw_pkg::COLUMNS - 1));
    assign w_last_row = (r_row == tmcw_pkg::ROW_W'(tmcw_pkg::ROWS - 1));
    assign w_rd_in_range = (i_read_row < tmcw_pkg::ROW_W'(tmcw_pkg::ROWS)) &&
                           (i_read_col < tmcw_pkg::COL_W'(tmcw_pkg::COLUMNS));

    // Status to the controller
    always_comb begin
        o_stat.clear_req   = (i_operation == tmcw_pkg::OP_CLEAR);
        o_stat.scroll_req  = w_is_put && w_row_end && w_last_row;
        o_stat.fill_last   = (r_cnt == CW'(tmcw_pkg::CELLS - 1));
        o_stat.scroll_last = (r_cnt == CW'(tmcw_pkg::CELLS));
    end

    // Next cursor for the offered transaction
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        case (i_operation)
            tmcw_pkg::OP_PUT: begin
                if (w_row_end) begin
                    n_col = '0;
                    if (!w_last_row) n_row = r_row + 1'b1;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            tmcw_pkg::OP_CLEAR: begin
                n_row = '0;
                n_col = '0;
            end
            default: ;
        endcase
    end

    // Cursor, colors and sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row        <= '0;
            r_col        <= '0;
            r_text_color <= tmcw_pkg::COLOR_AT_RESET;
            r_fill_color <= tmcw_pkg::COLOR_AT_RESET;
            r_cnt        <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_text_color <= i_cfg_text_color;
            end
            if (i_cmd.accept) begin
                r_row        <= n_row;
                r_col        <= n_col;
                r_fill_color <= r_text_color;
                r_cnt        <= '0;
            end else if (i_cmd.fill || i_cmd.scroll) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // Hold per-transaction flags for the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_scrolled <= o_stat.scroll_req;
            r_rd_ok    <= (i_operation == tmcw_pkg::OP_READ) && w_rd_in_range;
        end
    end

    // Scroll source address: one row below the write position
    assign w_src = r_cnt + CW'(tmcw_pkg::COLUMNS);

    // Screen RAM port selection
    always_comb begin
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = '0;
        w_raddr = '0;
        if (i_cmd.accept) begin
            w_we    = w_is_put && !w_is_nl;
            w_waddr = tmcw_pkg::cell_addr(r_row, r_col);
            w_wdata = {r_text_color, i_char_code};
            if (w_rd_in_range) w_raddr = tmcw_pkg::cell_addr(i_read_row, i_read_col);
        end else if (i_cmd.fill) begin
            w_we    = 1'b1;
            w_waddr = r_cnt[AW-1:0];
            w_wdata = {r_fill_color, tmcw_pkg::SPACE_CODE};
        end else if (i_cmd.scroll) begin
            // Read one step ahead; write the previous step's cell
            if (r_cnt < CW'(tmcw_pkg::MOVE_CELLS)) w_raddr = w_src[AW-1:0];
            w_we    = (r_cnt != '0);
            w_waddr = AW'(r_cnt - 1'b1);
            if (r_cnt <= CW'(tmcw_pkg::MOVE_CELLS)) begin
                w_wdata = {r_fill_color, w_rdata[tmcw_pkg::CHAR_W-1:0]};
            end else begin
                w_wdata = {r_fill_color, tmcw_pkg::SPACE_CODE};
            end
        end
    end

    tmcw_ram #(
        .WIDTH(tmcw_pkg::CELL_W),
        .DEPTH(tmcw_pkg::CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.resp;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.resp) begin
            r_out_char     <= r_rd_ok ? w_rdata[tmcw_pkg::CHAR_W-1:0] : '0;
            r_out_color    <= r_rd_ok ? w_rdata[tmcw_pkg::CELL_W-1:tmcw_pkg::CHAR_W] : '0;
            r_out_row      <= r_row;
            r_out_col      <= r_col;
            r_out_scrolled <= r_scrolled;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_cell_char  = r_out_char;
    assign o_cell_color = r_out_color;
    assign o_cursor_row = r_out_row;
    assign o_cursor_col = r_out_col;
    assign o_scrolled   = r_out_scrolled;

endmodule

### src/text_mode_console_writer.sv
// Top level of the text-mode console writer: controller plus datapath.
// Depends on tmcw_pkg, tmcw_ctrl, tmcw_dpath (and through it tmcw_ram).
//
// Usage:
//   Command channel: a transaction is taken at a rising edge with start high and
//   busy low. operation selects put character, clear screen or read one cell.
//   Result channel: o_strobe is high for one cycle with the cell bytes, the
//   cursor and the scroll flag; the receiver cannot stall it.
//   Configuration: i_cfg_valid with o_cfg_ready (high whenever out of reset)
//   writes the text color; write it only while no command is in flight.
// Sequencing:
//   Put without scroll, read, unused code: busy through the result state; the
//   result strobe is registered from it. A new command is taken once busy falls.
//   Clear: a fill sweep writes all 2000 cells, then the result state follows.
//   Scroll: the move sweep reads and writes one cell a cycle through the single
//   RAM port pair, then the result state follows.
// Reset:
//   Synchronous, active low. After it a clearing pass (busy high) writes spaces
//   in color 3 to all 2000 cells; config writes are taken meanwhile.
module text_mode_console_writer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_operation,
    input  logic [tmcw_pkg::CHAR_W-1:0] i_char_code,
    input  logic [tmcw_pkg::ROW_W-1:0]  i_read_row,
    input  logic [tmcw_pkg::COL_W-1:0]  i_read_col,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [tmcw_pkg::CHAR_W-1:0] i_cfg_text_color,
    output logic                        o_strobe,
    output logic [tmcw_pkg::CHAR_W-1:0] o_cell_char,
    output logic [tmcw_pkg::CHAR_W-1:0] o_cell_color,
    output logic [tmcw_pkg::ROW_W-1:0]  o_cursor_row,
    output logic [tmcw_pkg::COL_W-1:0]  o_cursor_col,
    output logic                        o_scrolled
);

    tmcw_pkg::t_dp_cmd  w_cmd;
    tmcw_pkg::t_dp_stat w_stat;

    // Color register takes every write once out of reset
    assign o_cfg_ready = i_rst_n;

    tmcw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    tmcw_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_operation      (i_operation),
        .i_char_code      (i_char_code),
        .i_read_row       (i_read_row),
        .i_read_col       (i_read_col),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_text_color (i_cfg_text_color),
        .o_strobe         (o_strobe),
        .o_cell_char      (o_cell_char),
        .o_cell_color     (o_cell_color),
        .o_cursor_row     (o_cursor_row),
        .o_cursor_col     (o_cursor_col),
        .o_scrolled       (o_scrolled)
    );

endmodule

### src/tmcw_checker.sv
// Port-level checks for the console writer, bound to the top level.
// Depends on tmcw_pkg.
module tmcw_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic [1:0]                  i_operation,
    input  logic                        o_strobe,
    input  logic [tmcw_pkg::ROW_W-1:0]  o_cursor_row,
    input  logic [tmcw_pkg::COL_W-1:0]  o_cursor_col,
    input  logic                        o_scrolled
);

    // Reset drops any pending result
    a_no_strobe_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("result strobe right after reset");

    // A read transaction answers through the result state and the registered strobe
    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_operation == tmcw_pkg::OP_READ) |=> ##1 o_strobe)
        else $error("read transaction result missing");

    // Results never come back to back
    a_strobe_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("back-to-back result strobes");

    // A scroll leaves the cursor at the start of the last row
    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_scrolled |->
            (o_cursor_row == tmcw_pkg::ROW_W'(tmcw_pkg::ROWS - 1)) && (o_cursor_col == '0))
        else $error("cursor misplaced after scroll");

    // Reported cursor stays on the screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_cursor_row < tmcw_pkg::ROW_W'(tmcw_pkg::ROWS)) &&
                     (o_cursor_col < tmcw_pkg::COL_W'(tmcw_pkg::COLUMNS)))
        else $error("cursor outside the screen");

endmodule

bind text_mode_console_writer tmcw_checker u_tmcw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_operation  (i_operation),
    .o_strobe     (o_strobe),
    .o_cursor_row (o_cursor_row),
    .o_cursor_col (o_cursor_col),
    .o_scrolled   (o_scrolled)
);
